### hdl/wasm_multi_value_type_scanner_unit_macros.svh
// assertion macros used by the checker file
`ifndef WASM_MULTI_VALUE_TYPE_SCANNER_UNIT_MACROS_SVH
`define WASM_MULTI_VALUE_TYPE_SCANNER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WMVS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define WMVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/wmvs_pkg.sv
`timescale 1ns / 1ps

package wmvs_pkg;

    // width of the byte position and the type section end, saturating
    localparam int POSITION_BITS = 32;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    // width of a position plus a 32-bit leb value, with a carry bit
    localparam int SUM_BITS = ((POSITION_BITS > 32) ? POSITION_BITS : 32) + 1;

    localparam int HEADER_LEN = 8;
    localparam logic [2:0] LEB_MAX_GROUPS = 3'd5;

    localparam logic [7:0] TYPE_SECTION_ID = 8'h01;
    localparam logic [7:0] FUNC_FORM = 8'h60;

    // magic 00 61 73 6d, version 01 00 00 00
    function automatic logic [7:0] header_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h00;
            3'd1:    b = 8'h61;
            3'd2:    b = 8'h73;
            3'd3:    b = 8'h6D;
            3'd4:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### hdl/wmvs_in_if.sv
`timescale 1ns / 1ps

interface wmvs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### hdl/wmvs_out_if.sv
`timescale 1ns / 1ps

interface wmvs_out_if;
    logic valid;
    logic ready;
    logic supports_multi_value;

    modport source (output valid, output supports_multi_value, input ready);
    modport sink (input valid, input supports_multi_value, output ready);
endinterface

### hdl/wasm_multi_value_type_scanner_unit.sv
`timescale 1ns / 1ps

// webassembly type section scanner: flags binaries that declare a function
// type with more than one result
//
// byte_in: one beat per binary byte, last_byte set on the final byte
// verdict_out: one beat per binary, sent after its final byte
//
// throughput: one byte per cycle while byte_in is ready; each beat updates the phase register and
// counters at the clock edge that accepts it
// latency: the verdict is valid the cycle after the final byte is accepted
//
// the verdict sits in an output register; byte_in stays ready while that
// register is empty or being drained, so only a held verdict that the
// receiver does not take stalls the byte stream
//
// reset clears all parse state and the output register; after every final
// byte the parse state returns to its reset values, so the next beat starts
// a new binary

module wasm_multi_value_type_scanner_unit (
    input  logic        clk,
    input  logic        rst_n,
    wmvs_in_if.sink     byte_in,
    wmvs_out_if.source  verdict_out
);
    import wmvs_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR,
        PH_ID,
        PH_SKSIZE,
        PH_SKIP,
        PH_TSIZE,
        PH_TCOUNT,
        PH_ENTRY,
        PH_PARAM,
        PH_PSKIP,
        PH_RESULT,
        PH_RSKIP
    } phase_t;

    localparam int PW = POSITION_BITS;

    // parse state
    logic [PW-1:0] pos_reg, pos_next;
    phase_t        phase_reg, phase_next;
    logic [31:0]   leb_val_reg, leb_val_next;
    logic [2:0]    leb_grp_reg, leb_grp_next;
    logic [31:0]   skip_reg, skip_next;
    logic [PW-1:0] tend_reg, tend_next;
    logic [31:0]   seen_reg, seen_next;
    logic [31:0]   total_reg, total_next;
    logic          found_reg, found_next;
    logic          fin_reg, fin_next;
    logic          bad_reg, bad_next;

    // output register
    logic out_valid_reg;
    logic out_bit_reg;

    logic          accept;
    logic [7:0]    b;
    logic          cont;
    logic [31:0]   leb_part;
    logic [31:0]   leb_acc;
    logic [2:0]    leb_grp_inc;
    logic [SUM_BITS-1:0] raw_sum;
    logic [PW-1:0] leb_sum;
    logic [31:0]   skip_dec;
    logic [31:0]   seen_inc;
    logic          in_sec;
    logic          verdict;

    assign byte_in.ready = !out_valid_reg || verdict_out.ready;
    assign accept        = byte_in.valid && byte_in.ready;
    assign b             = byte_in.data_byte;
    assign cont          = b[7];

    assign verdict_out.valid                = out_valid_reg;
    assign verdict_out.supports_multi_value = out_bit_reg;

    // leb128 group placement, groups after the fifth are dropped
    always_comb
    begin
        case (leb_grp_reg)
            3'd0:    leb_part = {25'd0, b[6:0]};
            3'd1:    leb_part = {18'd0, b[6:0], 7'd0};
            3'd2:    leb_part = {11'd0, b[6:0], 14'd0};
            3'd3:    leb_part = {4'd0, b[6:0], 21'd0};
            3'd4:    leb_part = {b[3:0], 28'd0};
            default: leb_part = 32'd0;
        endcase
    end

    assign leb_acc     = leb_val_reg | leb_part;
    assign leb_grp_inc = (leb_grp_reg < LEB_MAX_GROUPS) ? leb_grp_reg + 3'd1 : leb_grp_reg;

    // saturating position of the byte after this one
    assign pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + {{(PW-1){1'b0}}, 1'b1};
    assign in_sec   = pos_next < tend_reg;

    // saturating next position plus the leb value just completed
    assign raw_sum = SUM_BITS'(pos_next) + SUM_BITS'(leb_acc);
    assign leb_sum = (raw_sum > SUM_BITS'(POS_MAX)) ? POS_MAX : raw_sum[PW-1:0];

    assign skip_dec = (skip_reg != 32'd0) ? skip_reg - 32'd1 : 32'd0;
    assign seen_inc = seen_reg + 32'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        leb_val_next = leb_val_reg;
        leb_grp_next = leb_grp_reg;
        skip_next    = skip_reg;
        tend_next    = tend_reg;
        seen_next    = seen_reg;
        total_next   = total_reg;
        found_next   = found_reg;
        fin_next     = fin_reg;
        bad_next     = bad_reg;

        if (!fin_reg && !bad_reg)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    if (pos_reg < PW'(HEADER_LEN))
                    begin
                        if (b != header_byte(pos_reg[2:0]))
                            bad_next = 1'b1;
                        if (pos_reg == PW'(HEADER_LEN - 1))
                            phase_next = PH_ID;
                    end
                    else
                        phase_next = PH_ID;
                end
                PH_ID:
                begin
                    phase_next = (b == TYPE_SECTION_ID) ? PH_TSIZE : PH_SKSIZE;
                end
                PH_SKSIZE:
                begin
                    leb_val_next = leb_acc;
                    leb_grp_next = leb_grp_inc;
                    if (!cont)
                    begin
                        leb_val_next = 32'd0;
                        leb_grp_next = 3'd0;
                        if (leb_acc == 32'd0)
                            phase_next = PH_ID;
                        else
                        begin
                            skip_next  = leb_acc;
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 32'd0)
                        phase_next = PH_ID;
                end
                PH_TSIZE:
                begin
                    leb_val_next = leb_acc;
                    leb_grp_next = leb_grp_inc;
                    if (!cont)
                    begin
                        leb_val_next = 32'd0;
                        leb_grp_next = 3'd0;
                        tend_next    = leb_sum;
                        if (pos_next >= leb_sum)
                            fin_next = 1'b1;
                        else
                            phase_next = PH_TCOUNT;
                    end
                end
                PH_TCOUNT:
                begin
                    leb_val_next = leb_acc;
                    leb_grp_next = leb_grp_inc;
                    if (!(cont && in_sec))
                    begin
                        leb_val_next = 32'd0;
                        leb_grp_next = 3'd0;
                        total_next   = leb_acc;
                        seen_next    = 32'd0;
                        if (leb_acc != 32'd0 && in_sec)
                            phase_next = PH_ENTRY;
                        else
                            fin_next = 1'b1;
                    end
                end
                PH_ENTRY:
                begin
                    seen_next = seen_inc;
                    if (b != FUNC_FORM)
                    begin
                        // unknown form byte counts as an entry of its own
                        if (!(seen_inc < total_reg && in_sec))
                            fin_next = 1'b1;
                    end
                    else if (!in_sec)
                        fin_next = 1'b1;
                    else
                        phase_next = PH_PARAM;
                end
                PH_PARAM:
                begin
                    leb_val_next = leb_acc;
                    leb_grp_next = leb_grp_inc;
                    if (!(cont && in_sec))
                    begin
                        leb_val_next = 32'd0;
                        leb_grp_next = 3'd0;
                        if (leb_acc == 32'd0)
                        begin
                            if (in_sec)
                                phase_next = PH_RESULT;
                            else
                                fin_next = 1'b1;
                        end
                        else if (leb_sum >= tend_reg)
                            fin_next = 1'b1;
                        else
                        begin
                            skip_next  = leb_acc;
                            phase_next = PH_PSKIP;
                        end
                    end
                end
                PH_PSKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 32'd0)
                        phase_next = PH_RESULT;
                end
                PH_RESULT:
                begin
                    leb_val_next = leb_acc;
                    leb_grp_next = leb_grp_inc;
                    if (!(cont && in_sec))
                    begin
                        leb_val_next = 32'd0;
                        leb_grp_next = 3'd0;
                        if (leb_acc > 32'd1)
                        begin
                            found_next = 1'b1;
                            fin_next   = 1'b1;
                        end
                        else if (leb_acc == 32'd0)
                        begin
                            if (seen_reg < total_reg && in_sec)
                                phase_next = PH_ENTRY;
                            else
                                fin_next = 1'b1;
                        end
                        else if (leb_sum >= tend_reg || seen_reg >= total_reg)
                            fin_next = 1'b1;
                        else
                        begin
                            skip_next  = leb_acc;
                            phase_next = PH_RSKIP;
                        end
                    end
                end
                PH_RSKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 32'd0)
                        phase_next = PH_ENTRY;
                end
                default:
                begin
                    fin_next = 1'b1;
                end
            endcase
        end
    end

    // verdict uses the state as updated by the final byte
    assign verdict = !bad_next && (pos_reg >= PW'(HEADER_LEN - 1)) && found_next
                     && (tend_next <= pos_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            phase_reg     <= PH_HDR;
            leb_val_reg   <= '0;
            leb_grp_reg   <= '0;
            skip_reg      <= '0;
            tend_reg      <= '0;
            seen_reg      <= '0;
            total_reg     <= '0;
            found_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_bit_reg   <= 1'b0;
        end
        else
        begin
            if (verdict_out.ready)
                out_valid_reg <= 1'b0;

            if (accept)
            begin
                if (byte_in.last_byte)
                begin
                    // final byte: emit verdict and start over
                    out_valid_reg <= 1'b1;
                    out_bit_reg   <= verdict;
                    pos_reg       <= '0;
                    phase_reg     <= PH_HDR;
                    leb_val_reg   <= '0;
                    leb_grp_reg   <= '0;
                    skip_reg      <= '0;
                    tend_reg      <= '0;
                    seen_reg      <= '0;
                    total_reg     <= '0;
                    found_reg     <= 1'b0;
                    fin_reg       <= 1'b0;
                    bad_reg       <= 1'b0;
                end
                else
                begin
                    pos_reg     <= pos_next;
                    phase_reg   <= phase_next;
                    leb_val_reg <= leb_val_next;
                    leb_grp_reg <= leb_grp_next;
                    skip_reg    <= skip_next;
                    tend_reg    <= tend_next;
                    seen_reg    <= seen_next;
                    total_reg   <= total_next;
                    found_reg   <= found_next;
                    fin_reg     <= fin_next;
                    bad_reg     <= bad_next;
                end
            end
        end
    end

endmodule

### hdl/wmvs_checker.sv
`timescale 1ns / 1ps
`include "wasm_multi_value_type_scanner_unit_macros.svh"

module wmvs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready,
    input logic out_bit
);

    // a held verdict keeps its beat until taken
    `WMVS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bit), "verdict dropped or changed while stalled")

    // a new verdict only follows an accepted final byte
    `WMVS_ASSERT_NOW(a_out_cause, $rose(out_valid), $past(in_valid && in_ready && in_last), "verdict without final byte")

    // an ordinary byte into an empty output gives no verdict
    `WMVS_ASSERT_NEXT(a_no_spurious, in_valid && in_ready && !in_last && !out_valid, !out_valid, "verdict after non-final byte")

    // the byte stream only stalls behind a held verdict
    `WMVS_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind wasm_multi_value_type_scanner_unit wmvs_checker u_wmvs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_in.valid),
    .in_ready  (byte_in.ready),
    .in_last   (byte_in.last_byte),
    .out_valid (verdict_out.valid),
    .out_ready (verdict_out.ready),
    .out_bit   (verdict_out.supports_multi_value)
);
